// File: design/bst_pkg.sv
// Package with shared constants and types for the Bezier segment tessellator.
package bst_pkg;

	localparam int MAX_STEPS_DEF  = 63;
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 4;
	localparam int STEP_BITS      = 6;
	localparam int T_BITS         = 17;
	localparam logic [T_BITS-1:0] ONE_Q16 = 17'h10000;

	localparam logic DEG_QUAD  = 1'b0;
	localparam logic DEG_CUBIC = 1'b1;

	// Sideband that travels down the evaluation pipeline with each step.
	typedef struct packed {
		logic cubic;
		logic first;
		logic last;
	} step_ctl_t;

endpackage

// File: design/bst_if.sv
// Valid/ready channel interface carrying a packed payload.
interface bst_if #(
	parameter int W = 8
) (
	input logic clk
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/bst_stepper.sv
// Step sequencer: holds one curve and issues t values for i = 0..n.
module bst_stepper #(
	parameter int MAX_STEPS = bst_pkg::MAX_STEPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            in_cubic,
	input  logic [bst_pkg::STEP_BITS-1:0]   in_count,
	input  logic                            hold,
	input  logic                            adv,
	output logic                            st_valid,
	output logic [bst_pkg::T_BITS-1:0]      st_t,
	output bst_pkg::step_ctl_t              st_ctl
);
	logic                          busy_q;
	logic                          cubic_q;
	logic [bst_pkg::STEP_BITS-1:0] n_q;
	logic [bst_pkg::STEP_BITS-1:0] i_q;
	logic [bst_pkg::STEP_BITS:0]   rem_q;
	logic [bst_pkg::T_BITS-1:0]    t_q;
	logic [bst_pkg::T_BITS-1:0]    qstep_q;
	logic [bst_pkg::STEP_BITS-1:0] rstep_q;
	logic [bst_pkg::STEP_BITS-1:0] n_in;
	logic [bst_pkg::STEP_BITS:0]   rem_nx;
	logic                          wrap;
	logic [bst_pkg::T_BITS-1:0]    q_tab [64];
	logic [bst_pkg::STEP_BITS-1:0] r_tab [64];

	// Quotient and remainder of 65536/n from a small constant table.
	assign q_tab[0] = '0;
	assign r_tab[0] = '0;
	for (genvar g = 1; g < 64; g++) begin : g_div
		localparam int QV = 65536 / g;
		localparam int RV = 65536 % g;
		assign q_tab[g] = bst_pkg::T_BITS'(QV);
		assign r_tab[g] = bst_pkg::STEP_BITS'(RV);
	end

	always_comb begin
		n_in = in_count;
		if (n_in == '0) n_in = bst_pkg::STEP_BITS'(1);
		if (n_in > bst_pkg::STEP_BITS'(MAX_STEPS)) n_in = bst_pkg::STEP_BITS'(MAX_STEPS);
	end

	// A new curve waits until the older steps have left the stages that read the points.
	assign in_ready = !busy_q && !hold;
	assign st_valid = busy_q;
	assign st_t = t_q;
	assign st_ctl = '{cubic: cubic_q, first: (i_q == '0), last: (i_q == n_q)};

	assign rem_nx = rem_q + {1'b0, rstep_q};
	assign wrap = rem_nx >= {1'b0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
		end else if (busy_q && adv && i_q == n_q) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cubic_q <= in_cubic;
			n_q     <= n_in;
			i_q     <= '0;
			rem_q   <= '0;
			t_q     <= '0;
			qstep_q <= q_tab[n_in];
			rstep_q <= r_tab[n_in];
		end else if (busy_q && adv) begin
			i_q   <= i_q + 1'b1;
			rem_q <= wrap ? rem_nx - {1'b0, n_q} : rem_nx;
			t_q   <= t_q + qstep_q + (wrap ? bst_pkg::T_BITS'(1) : '0);
		end
	end
endmodule

// File: design/bst_axis_eval.sv
// Four-stage Bernstein evaluation for both axes with a stall-aware valid chain.
module bst_axis_eval #(
	parameter int COORD_BITS = bst_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [bst_pkg::T_BITS-1:0]   in_t,
	input  bst_pkg::step_ctl_t           in_ctl,
	input  logic signed [15:0]           px [4],
	input  logic signed [15:0]           py [4],
	output logic                         pend,
	output logic                         out_valid,
	output bst_pkg::step_ctl_t           out_ctl,
	output logic [COORD_BITS-1:0]        out_x,
	output logic [COORD_BITS-1:0]        out_y
);
	localparam int AW = 52;

	logic                       v_s1, v_s2, v_s3, v_s4;
	bst_pkg::step_ctl_t         c_s1, c_s2, c_s3, c_s4;
	logic [bst_pkg::T_BITS-1:0] t_s1, u_s1;
	logic [33:0]                uu_full, tt_full;
	logic [bst_pkg::T_BITS-1:0] t_s2, u_s2, uu_s2, tt_s2;
	logic [bst_pkg::T_BITS-1:0] b_s3 [4];
	logic signed [AW-1:0]       ax_s4, ay_s4;
	logic [bst_pkg::T_BITS-1:0] b_nx [4];
	logic signed [AW-1:0]       sx, sy;

	function automatic logic [bst_pkg::T_BITS-1:0] mulq(input logic [bst_pkg::T_BITS+1:0] a,
		input logic [bst_pkg::T_BITS-1:0] b);
		logic [2*bst_pkg::T_BITS+1:0] p;
		p = a * b;
		return p[16 +: bst_pkg::T_BITS];
	endfunction

	function automatic logic [COORD_BITS-1:0] rsat(input logic signed [AW-1:0] acc);
		logic signed [AW-1:0] q;
		logic signed [AW-1:0] hi, lo;
		q  = (acc + AW'(32768)) >>> 16;
		hi = (AW'(1) <<< (COORD_BITS - 1)) - AW'(1);
		lo = -hi - AW'(1);
		if (q > hi) q = hi;
		if (q < lo) q = lo;
		return q[COORD_BITS-1:0];
	endfunction

	assign uu_full = u_s1 * u_s1;
	assign tt_full = t_s1 * t_s1;

	always_comb begin
		if (c_s2.cubic) begin
			b_nx[0] = mulq({2'b0, uu_s2}, u_s2);
			b_nx[1] = mulq({1'b0, uu_s2, 1'b0} + {2'b0, uu_s2}, t_s2);
			b_nx[2] = mulq({1'b0, u_s2, 1'b0} + {2'b0, u_s2}, tt_s2);
			b_nx[3] = mulq({2'b0, tt_s2}, t_s2);
		end else begin
			b_nx[0] = uu_s2;
			b_nx[1] = mulq({1'b0, u_s2, 1'b0}, t_s2);
			b_nx[2] = tt_s2;
			b_nx[3] = '0;
		end
	end

	always_comb begin
		sx = '0;
		sy = '0;
		for (int k = 0; k < 4; k++) begin
			sx = sx + $signed({1'b0, b_s3[k]}) * AW'(px[k]);
			sy = sy + $signed({1'b0, b_s3[k]}) * AW'(py[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4} <= {in_valid, v_s1, v_s2, v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= in_t;
			u_s1  <= bst_pkg::ONE_Q16 - in_t;
			c_s1  <= in_ctl;
			t_s2  <= t_s1;
			u_s2  <= u_s1;
			uu_s2 <= uu_full[16 +: bst_pkg::T_BITS];
			tt_s2 <= tt_full[16 +: bst_pkg::T_BITS];
			c_s2  <= c_s1;
			b_s3  <= b_nx;
			c_s3  <= c_s2;
			ax_s4 <= sx;
			ay_s4 <= sy;
			c_s4  <= c_s3;
		end
	end

	// Steps in the first three stages still need the held control points.
	assign pend      = v_s1 || v_s2 || v_s3;
	assign out_valid = v_s4;
	assign out_ctl   = c_s4;
	assign out_x     = rsat(ax_s4);
	assign out_y     = rsat(ay_s4);
endmodule

// File: design/bezier_segment_tessellator.sv
// Top level of the Bezier segment tessellator.
//
//  channel | direction | payload
//  in      | sink      | action, subdivisions, p1_x..p4_y
//  out     | source    | start_x, start_y, end_x, end_y, last_segment
//
// A curve with count n (0 read as 1, capped at MAX_STEPS) gives n+1 segments,
// one per cycle while the output is free. The input stays closed while the
// steps are issued and until the last step has left the stages that read the
// held control points. Each result passes through the evaluation stages and
// then the output register. Reset clears all valid bits and the sequencer.
// A stall on the output freezes the whole pipeline, so no request is dropped
// or repeated.
module bezier_segment_tessellator #(
	parameter int MAX_STEPS  = bst_pkg::MAX_STEPS_DEF,
	parameter int COORD_BITS = bst_pkg::COORD_BITS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	bst_if.sink   in,
	bst_if.source out
);
	logic                          st_valid;
	logic [bst_pkg::T_BITS-1:0]    st_t;
	bst_pkg::step_ctl_t            st_ctl;
	logic                          ev_valid;
	logic                          ev_pend;
	bst_pkg::step_ctl_t            ev_ctl;
	logic [COORD_BITS-1:0]         ev_x, ev_y;
	logic                          en;
	logic signed [15:0]            px [4];
	logic signed [15:0]            py [4];
	logic [COORD_BITS-1:0]         prev_x_q, prev_y_q;
	logic                          load;

	// The input word packs action, subdivisions, then p1_x..p4_y, low to high.
	assign load = in.valid && in.ready;

	// Control points are captured at acceptance and held for the whole curve.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < 4; k++) begin
				px[k] <= in.data[7 + 32*k +: 16];
				py[k] <= in.data[23 + 32*k +: 16];
			end
		end
	end

	// The pipeline advances whenever its output slot is empty or being taken.
	assign en = !out.valid || out.ready;

	bst_stepper #(.MAX_STEPS(MAX_STEPS)) u_step (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.in_cubic(in.data[0]), .in_count(in.data[6:1]),
		.hold(ev_pend),
		.adv(en), .st_valid(st_valid), .st_t(st_t), .st_ctl(st_ctl)
	);

	bst_axis_eval #(.COORD_BITS(COORD_BITS)) u_eval (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(st_valid), .in_t(st_t), .in_ctl(st_ctl),
		.px(px), .py(py), .pend(ev_pend),
		.out_valid(ev_valid), .out_ctl(ev_ctl), .out_x(ev_x), .out_y(ev_y)
	);

	// Output register; the start point is the previous end, or the point itself
	// on the first step of a curve.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out.valid <= 1'b0;
		end else if (en) begin
			out.valid <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ev_valid) begin
			out.data <= {ev_ctl.last, ev_y, ev_x,
				ev_ctl.first ? ev_y : prev_y_q, ev_ctl.first ? ev_x : prev_x_q};
			prev_x_q <= ev_x;
			prev_y_q <= ev_y;
		end
	end
endmodule

// File: design/bst_checker.sv
// Port-level checker for the Bezier segment tessellator, bound to the top level.
module bst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [64:0] out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");
	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !in_ready |=> !in_ready)
		else $error("curve released during stall");
endmodule

bind bezier_segment_tessellator bst_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);
